// ===== hw/rtl/clfp_pkg.sv =====
package clfp_pkg;

   localparam int unsigned HDR_LIMIT_W = 16;
   localparam int unsigned LEN_W       = 25;
   localparam int unsigned HCOUNT_W    = 17;
   localparam int unsigned CSR_IDX_W   = 4;

   localparam logic [HDR_LIMIT_W-1:0] HDR_LIMIT_RESET = 16'd8192;
   localparam logic [LEN_W-1:0]       HARD_BODY_MAX   = 25'd16777216;
   localparam logic [LEN_W-1:0]       ACC_SAT         = 25'h1FF_FFFF;
   localparam logic [HCOUNT_W-1:0]    HCOUNT_MAX      = 17'h1_FFFF;
   localparam logic [3:0]             NAME_LEN        = 4'd14;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_LIMIT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_LIMIT   = 4'd1;

   // result kinds
   localparam logic [1:0] KIND_BODY  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [3:0] ERR_INCOMPLETE_HEADERS = 4'd0;
   localparam logic [3:0] ERR_HEADER_LIMIT       = 4'd1;
   localparam logic [3:0] ERR_MALFORMED_LINE     = 4'd2;
   localparam logic [3:0] ERR_DUPLICATE_LENGTH   = 4'd3;
   localparam logic [3:0] ERR_EMPTY_LENGTH       = 4'd4;
   localparam logic [3:0] ERR_INVALID_LENGTH     = 4'd5;
   localparam logic [3:0] ERR_LENGTH_RANGE       = 4'd6;
   localparam logic [3:0] ERR_MISSING_LENGTH     = 4'd7;
   localparam logic [3:0] ERR_TRUNCATED_BODY     = 4'd8;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   typedef enum logic [1:0] {
      MODE_HEADER,
      MODE_BODY,
      MODE_HALT
   } mode_type;

   typedef enum logic [1:0] {
      VP_LEAD,
      VP_DIGITS,
      VP_TRAIL
   } vphase_type;

   typedef struct packed {
      logic             nonempty;
      logic             colon_seen;
      logic             colon_at_start;
      logic [3:0]       match_idx;
      logic             mismatch;
      vphase_type       vphase;
      logic             bad;
      logic [LEN_W-1:0] accum;
   } line_type;

   localparam line_type LINE_CLEAR = '{
      nonempty:       1'b0,
      colon_seen:     1'b0,
      colon_at_start: 1'b0,
      match_idx:      4'd0,
      mismatch:       1'b0,
      vphase:         VP_LEAD,
      bad:            1'b0,
      accum:          '0
   };

   // lower-case header name that carries the body length
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] ch;
      begin
         case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
         endcase
         return ch;
      end
   endfunction

endpackage

// ===== hw/rtl/clfp_if.sv =====
interface clfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source(output valid, data_byte, end_of_input, input ready);
   modport sink(input valid, data_byte, end_of_input, output ready);
endinterface

interface clfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  body_byte;
   logic        last_body;
   logic [3:0]  fault_code;
   logic [24:0] body_length;

   modport source(output valid, kind, body_byte, last_body, fault_code, body_length,
                  input ready);
   modport sink(input valid, kind, body_byte, last_body, fault_code, body_length,
                output ready);
endinterface

interface clfp_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [24:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/content_length_frame_parser_core.sv =====
// Channel  Direction  Payload
// req      in         data_byte[7:0], end_of_input
// rsp      out        kind[1:0], body_byte[7:0], last_body, fault_code[3:0], body_length[24:0]
// csr      in         index[3:0], data[24:0] (0 header_limit, 1 body_limit)
//
// One item per cycle sustained while rsp does not stall. The accepted item is parsed straight
// out of the input register, and its result is registered in the result register that drives
// rsp. The longest path is the held CR step feeding the decimal accumulate (times ten plus
// digit, saturating).
// Reset clears all parser state and loads both limits with their reset values.
// While rsp stalls with a result waiting, the input register takes one more item, then req stalls.
module content_length_frame_parser_core (
   input logic        clock,
   input logic        reset,
   clfp_req_if.sink   req,
   clfp_rsp_if.source rsp,
   clfp_csr_if.sink   csr
);

   // configuration
   logic [clfp_pkg::HDR_LIMIT_W-1:0] header_limit_ff;
   logic [clfp_pkg::LEN_W-1:0]       body_limit_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;

   // parser state
   clfp_pkg::mode_type              mode_ff, mode_in;
   logic [clfp_pkg::HCOUNT_W-1:0]   header_count_ff, header_count_in;
   logic                            pending_cr_ff, pending_cr_in;
   clfp_pkg::line_type              line_ff, line_in;
   logic                            length_seen_ff, length_seen_in;
   logic [clfp_pkg::LEN_W-1:0]      declared_length_ff, declared_length_in;
   logic [clfp_pkg::LEN_W-1:0]      body_remaining_ff, body_remaining_in;

   // result register
   logic                       out_valid_ff;
   logic [1:0]                 out_kind_ff;
   logic [7:0]                 out_byte_ff;
   logic                       out_last_ff;
   logic [3:0]                 out_code_ff;
   logic [clfp_pkg::LEN_W-1:0] out_length_ff;

   logic room;
   logic advance;

   // step decode
   logic [clfp_pkg::HCOUNT_W-1:0] count_inc;
   logic                          hdr_over;
   logic                          is_lf;
   logic                          body_last;
   logic [clfp_pkg::LEN_W-1:0]    len_lim;
   logic                          is_len_name;
   logic                          le_fail;
   logic [3:0]                    le_code;
   logic                          le_body;
   logic                          le_take;
   clfp_pkg::line_type            line_mid, line_nxt;

   logic       res_valid;
   logic [1:0] res_kind;
   logic       res_last;
   logic [3:0] res_code;

   function automatic clfp_pkg::line_type line_char(input clfp_pkg::line_type l,
                                                     input logic [7:0] ch);
      clfp_pkg::line_type r;
      logic [7:0]         lc;
      logic               first;
      logic               blank;
      logic               digit;
      logic [28:0]        wide;
      begin
         r = l;
         first = !l.nonempty;
         r.nonempty = 1'b1;
         lc = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
         blank = (ch == clfp_pkg::CHAR_SPACE) || (ch == clfp_pkg::CHAR_TAB);
         digit = (ch >= "0") && (ch <= "9");
         wide = ({4'd0, l.accum} << 3) + ({4'd0, l.accum} << 1) + {25'd0, ch[3:0]};
         if (!l.colon_seen) begin
            if (ch == clfp_pkg::CHAR_COLON) begin
               r.colon_seen = 1'b1;
               r.colon_at_start = first;
            end else if (l.match_idx >= clfp_pkg::NAME_LEN ||
                         lc != clfp_pkg::name_char(l.match_idx)) begin
               r.mismatch = 1'b1;
            end else begin
               r.match_idx = l.match_idx + 4'd1;
            end
         end else begin
            case (l.vphase)
               clfp_pkg::VP_LEAD: begin
                  if (!blank) begin
                     r.vphase = clfp_pkg::VP_DIGITS;
                     if (digit) begin
                        r.accum = {21'd0, ch[3:0]};
                     end else begin
                        r.bad = 1'b1;
                     end
                  end
               end
               clfp_pkg::VP_DIGITS: begin
                  if (blank) begin
                     r.vphase = clfp_pkg::VP_TRAIL;
                  end else if (digit) begin
                     // saturate instead of wrapping
                     if (wide > {4'd0, clfp_pkg::ACC_SAT}) begin
                        r.accum = clfp_pkg::ACC_SAT;
                     end else begin
                        r.accum = wide[clfp_pkg::LEN_W-1:0];
                     end
                  end else begin
                     r.bad = 1'b1;
                  end
               end
               default: begin
                  if (!blank) begin
                     r.bad = 1'b1;
                  end
               end
            endcase
         end
         return r;
      end
   endfunction

   assign room    = !out_valid_ff || rsp.ready;
   assign advance = in_valid_ff && room;
   assign req.ready = !in_valid_ff || room;
   assign csr.ready = 1'b1;

   assign count_inc = header_count_ff +
                      {{(clfp_pkg::HCOUNT_W-1){1'b0}},
                       (header_count_ff != clfp_pkg::HCOUNT_MAX)};
   assign hdr_over  = count_inc > {1'b0, header_limit_ff};
   assign is_lf     = in_byte_ff == clfp_pkg::CHAR_LF;
   assign body_last = body_remaining_ff <= 25'd1;
   assign len_lim   = (body_limit_ff < clfp_pkg::HARD_BODY_MAX) ? body_limit_ff
                                                               : clfp_pkg::HARD_BODY_MAX;
   assign is_len_name = !line_ff.mismatch && (line_ff.match_idx == clfp_pkg::NAME_LEN);

   // a held CR turns into line content once the next byte is not LF
   assign line_mid = pending_cr_ff ? line_char(line_ff, clfp_pkg::CHAR_CR) : line_ff;
   assign line_nxt = (in_byte_ff == clfp_pkg::CHAR_CR) ? line_mid
                                                       : line_char(line_mid, in_byte_ff);

   // line end checks
   always_comb begin
      le_fail = 1'b0;
      le_code = clfp_pkg::ERR_INCOMPLETE_HEADERS;
      le_body = 1'b0;
      le_take = 1'b0;
      if (!line_ff.nonempty) begin
         if (!length_seen_ff) begin
            le_fail = 1'b1;
            le_code = clfp_pkg::ERR_MISSING_LENGTH;
         end else begin
            le_body = 1'b1;
         end
      end else if (!line_ff.colon_seen || line_ff.colon_at_start) begin
         le_fail = 1'b1;
         le_code = clfp_pkg::ERR_MALFORMED_LINE;
      end else if (is_len_name) begin
         le_fail = 1'b1;
         if (length_seen_ff) begin
            le_code = clfp_pkg::ERR_DUPLICATE_LENGTH;
         end else if (line_ff.vphase == clfp_pkg::VP_LEAD && !line_ff.bad) begin
            le_code = clfp_pkg::ERR_EMPTY_LENGTH;
         end else if (line_ff.bad) begin
            le_code = clfp_pkg::ERR_INVALID_LENGTH;
         end else if (line_ff.accum == '0 || line_ff.accum > len_lim) begin
            le_code = clfp_pkg::ERR_LENGTH_RANGE;
         end else begin
            le_fail = 1'b0;
            le_take = 1'b1;
         end
      end
   end

   // result of the item in the input register
   always_comb begin
      res_valid = 1'b0;
      res_kind  = clfp_pkg::KIND_BODY;
      res_last  = 1'b0;
      res_code  = clfp_pkg::ERR_INCOMPLETE_HEADERS;
      case (mode_ff)
         clfp_pkg::MODE_BODY: begin
            res_valid = 1'b1;
            if (in_eoi_ff) begin
               res_kind = clfp_pkg::KIND_ERROR;
               res_code = clfp_pkg::ERR_TRUNCATED_BODY;
            end else begin
               res_last = body_last;
            end
         end
         clfp_pkg::MODE_HEADER: begin
            if (in_eoi_ff) begin
               res_valid = 1'b1;
               if (header_count_ff == '0) begin
                  res_kind = clfp_pkg::KIND_END;
               end else begin
                  res_kind = clfp_pkg::KIND_ERROR;
               end
            end else if (hdr_over) begin
               res_valid = 1'b1;
               res_kind  = clfp_pkg::KIND_ERROR;
               res_code  = clfp_pkg::ERR_HEADER_LIMIT;
            end else if (is_lf && le_fail) begin
               res_valid = 1'b1;
               res_kind  = clfp_pkg::KIND_ERROR;
               res_code  = le_code;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // next parser state
   always_comb begin
      mode_in            = mode_ff;
      header_count_in    = header_count_ff;
      pending_cr_in      = pending_cr_ff;
      line_in            = line_ff;
      length_seen_in     = length_seen_ff;
      declared_length_in = declared_length_ff;
      body_remaining_in  = body_remaining_ff;
      if (advance) begin
         case (mode_ff)
            clfp_pkg::MODE_BODY: begin
               if (in_eoi_ff) begin
                  mode_in = clfp_pkg::MODE_HALT;
               end else if (body_last) begin
                  // start the next frame
                  mode_in            = clfp_pkg::MODE_HEADER;
                  header_count_in    = '0;
                  pending_cr_in      = 1'b0;
                  line_in            = clfp_pkg::LINE_CLEAR;
                  length_seen_in     = 1'b0;
                  declared_length_in = '0;
                  body_remaining_in  = '0;
               end else begin
                  body_remaining_in = body_remaining_ff - 25'd1;
               end
            end
            clfp_pkg::MODE_HEADER: begin
               if (in_eoi_ff) begin
                  mode_in = clfp_pkg::MODE_HALT;
               end else begin
                  header_count_in = count_inc;
                  if (hdr_over) begin
                     mode_in = clfp_pkg::MODE_HALT;
                  end else if (is_lf) begin
                     pending_cr_in = 1'b0;
                     line_in       = clfp_pkg::LINE_CLEAR;
                     if (le_fail) begin
                        mode_in = clfp_pkg::MODE_HALT;
                     end else if (le_body) begin
                        mode_in           = clfp_pkg::MODE_BODY;
                        body_remaining_in = declared_length_ff;
                     end else if (le_take) begin
                        length_seen_in     = 1'b1;
                        declared_length_in = line_ff.accum;
                     end
                  end else begin
                     pending_cr_in = in_byte_ff == clfp_pkg::CHAR_CR;
                     line_in       = line_nxt;
                  end
               end
            end
            default: begin
               mode_in = clfp_pkg::MODE_HALT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_limit_ff <= clfp_pkg::HDR_LIMIT_RESET;
         body_limit_ff   <= clfp_pkg::HARD_BODY_MAX;
      end else if (csr.valid) begin
         if (csr.index == clfp_pkg::CSR_HEADER_LIMIT) begin
            header_limit_ff <= csr.data[clfp_pkg::HDR_LIMIT_W-1:0];
         end else if (csr.index == clfp_pkg::CSR_BODY_LIMIT) begin
            body_limit_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
         in_eoi_ff  <= req.end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= clfp_pkg::MODE_HEADER;
         header_count_ff    <= '0;
         pending_cr_ff      <= 1'b0;
         line_ff            <= clfp_pkg::LINE_CLEAR;
         length_seen_ff     <= 1'b0;
         declared_length_ff <= '0;
         body_remaining_ff  <= '0;
      end else begin
         mode_ff            <= mode_in;
         header_count_ff    <= header_count_in;
         pending_cr_ff      <= pending_cr_in;
         line_ff            <= line_in;
         length_seen_ff     <= length_seen_in;
         declared_length_ff <= declared_length_in;
         body_remaining_ff  <= body_remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (room) begin
         out_valid_ff <= advance && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_kind_ff   <= res_kind;
         out_byte_ff   <= (res_kind == clfp_pkg::KIND_BODY) ? in_byte_ff : 8'd0;
         out_last_ff   <= res_last;
         out_code_ff   <= res_code;
         out_length_ff <= declared_length_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = out_kind_ff;
   assign rsp.body_byte   = out_byte_ff;
   assign rsp.last_body   = out_last_ff;
   assign rsp.fault_code  = out_code_ff;
   assign rsp.body_length = out_length_ff;

endmodule

// ===== bench/tb_content_length_frame_parser_core.sv =====
`timescale 1ns / 100ps

module tb_content_length_frame_parser_core;
   import clfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES  = 5000;
   localparam int unsigned PHASE_ITEMS   = 265;
   localparam int unsigned PHASES        = 6;
   localparam int unsigned PRESSURE_LEN  = 200;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_BODY_LIMIT + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = '1;
   localparam logic [3:0]           END_CLEAN       = ERR_TRUNCATED_BODY + 1'b1;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       body_byte;
      logic             last_body;
      logic [3:0]       fault_code;
      logic [LEN_W-1:0] body_length;
   } parse_result_type;

   // Tracks the deframer state and holds the results it must produce, oldest first.
   class deframe_checker;
      logic [HDR_LIMIT_W-1:0] hdr_limit;
      logic [LEN_W-1:0]       body_cap;
      mode_type               mode;
      logic [HCOUNT_W-1:0]    hdr_count;
      bit                     cr_held;
      line_type               ln;
      bit                     len_seen;
      logic [LEN_W-1:0]       decl_len;
      logic [LEN_W-1:0]       body_left;
      string                  len_name;
      parse_result_type       due_outputs[$];
      int unsigned            mismatches;
      int unsigned            results_seen;

      function new();
         len_name     = "content-length";
         hdr_limit    = HDR_LIMIT_RESET;
         body_cap     = HARD_BODY_MAX;
         mismatches   = 0;
         results_seen = 0;
         reset_frame();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
         if (idx == CSR_HEADER_LIMIT) begin
            hdr_limit = value[HDR_LIMIT_W-1:0];
         end else if (idx == CSR_BODY_LIMIT) begin
            body_cap = value;
         end
      endfunction

      function void reset_line();
         cr_held = 1'b0;
         ln      = LINE_CLEAR;
      endfunction

      function void reset_frame();
         reset_line();
         mode      = MODE_HEADER;
         hdr_count = '0;
         len_seen  = 1'b0;
         decl_len  = '0;
         body_left = '0;
      endfunction

      function void queue_result(logic [1:0] kind, logic [7:0] b, logic is_last,
                                 logic [3:0] code);
         parse_result_type r;
         r.kind        = kind;
         r.body_byte   = b;
         r.last_body   = is_last;
         r.fault_code  = code;
         r.body_length = decl_len;
         due_outputs   = {due_outputs, r};
      endfunction

      function void halt_on(logic [3:0] code);
         mode = MODE_HALT;
         queue_result(KIND_ERROR, '0, 1'b0, code);
      endfunction

      function void absorb_char(logic [7:0] c);
         bit          first;
         bit          blank;
         bit          digit;
         logic [7:0]  lc;
         int unsigned d;
         first       = !ln.nonempty;
         ln.nonempty = 1'b1;
         if (!ln.colon_seen) begin
            if (c == CHAR_COLON) begin
               ln.colon_seen     = 1'b1;
               ln.colon_at_start = first;
               return;
            end
            lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
            if (ln.match_idx >= NAME_LEN || lc != len_name[ln.match_idx])
               ln.mismatch = 1'b1;
            else
               ln.match_idx = ln.match_idx + 1'b1;
            return;
         end
         blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
         digit = (c >= "0") && (c <= "9");
         d     = digit ? c - 8'd48 : 0;
         case (ln.vphase)
            VP_LEAD: begin
               if (!blank) begin
                  ln.vphase = VP_DIGITS;
                  if (digit) ln.accum = LEN_W'(d);
                  else ln.bad = 1'b1;
               end
            end
            VP_DIGITS: begin
               if (blank) begin
                  ln.vphase = VP_TRAIL;
               end else if (digit) begin
                  // saturate instead of wrapping
                  if (ln.accum > (ACC_SAT - d) / 10) ln.accum = ACC_SAT;
                  else ln.accum = LEN_W'(ln.accum * 10 + d);
               end else begin
                  ln.bad = 1'b1;
               end
            end
            default: begin
               if (!blank) ln.bad = 1'b1;
            end
         endcase
      endfunction

      function void finish_line();
         logic [LEN_W-1:0] cap;
         if (!ln.nonempty) begin
            if (!len_seen) begin
               halt_on(ERR_MISSING_LENGTH);
               return;
            end
            mode      = MODE_BODY;
            body_left = decl_len;
            reset_line();
            return;
         end
         if (!ln.colon_seen || ln.colon_at_start) begin
            halt_on(ERR_MALFORMED_LINE);
            return;
         end
         if (!ln.mismatch && ln.match_idx == NAME_LEN) begin
            cap = (body_cap < HARD_BODY_MAX) ? body_cap : HARD_BODY_MAX;
            if (len_seen) begin
               halt_on(ERR_DUPLICATE_LENGTH);
               return;
            end
            len_seen = 1'b1;
            if (ln.vphase == VP_LEAD && !ln.bad) begin
               halt_on(ERR_EMPTY_LENGTH);
               return;
            end
            if (ln.bad) begin
               halt_on(ERR_INVALID_LENGTH);
               return;
            end
            if (ln.accum == 0 || ln.accum > cap) begin
               halt_on(ERR_LENGTH_RANGE);
               return;
            end
            decl_len = ln.accum;
         end
         reset_line();
      endfunction

      function void track_input(logic [7:0] b, logic eoi);
         bit is_last;
         if (mode == MODE_HALT) return;
         if (mode == MODE_BODY) begin
            if (eoi) begin
               halt_on(ERR_TRUNCATED_BODY);
               return;
            end
            is_last = (body_left <= 1);
            queue_result(KIND_BODY, b, is_last, '0);
            if (is_last) reset_frame();
            else body_left = body_left - 1'b1;
            return;
         end
         if (eoi) begin
            if (hdr_count == 0) begin
               mode = MODE_HALT;
               queue_result(KIND_END, '0, 1'b0, '0);
            end else begin
               halt_on(ERR_INCOMPLETE_HEADERS);
            end
            return;
         end
         if (hdr_count < HCOUNT_MAX) hdr_count = hdr_count + 1'b1;
         if (hdr_count > hdr_limit) begin
            halt_on(ERR_HEADER_LIMIT);
            return;
         end
         if (b == CHAR_LF) begin
            cr_held = 1'b0;
            finish_line();
            return;
         end
         // a held CR that is not followed by LF is line content
         if (cr_held) begin
            cr_held = 1'b0;
            absorb_char(CHAR_CR);
         end
         if (b == CHAR_CR) cr_held = 1'b1;
         else absorb_char(b);
      endfunction

      task report(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_field(string what, logic [LEN_W-1:0] got_v, logic [LEN_W-1:0] exp_v);
         if (got_v !== exp_v)
            report($sformatf("result %0d %s: got %0h, expected %0h",
                             results_seen, what, got_v, exp_v));
      endtask

      task match_output(parse_result_type got);
         parse_result_type exp;
         results_seen++;
         if (due_outputs.size() == 0) begin
            report($sformatf("result %0d arrived with none expected: kind %0h code %0h",
                             results_seen, got.kind, got.fault_code));
            return;
         end
         exp = due_outputs[0];
         due_outputs.delete(0);
         check_field("kind", LEN_W'(got.kind), LEN_W'(exp.kind));
         check_field("body_byte", LEN_W'(got.body_byte), LEN_W'(exp.body_byte));
         check_field("last_body", LEN_W'(got.last_body), LEN_W'(exp.last_body));
         check_field("fault_code", LEN_W'(got.fault_code), LEN_W'(exp.fault_code));
         check_field("body_length", got.body_length, exp.body_length);
      endtask
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   bit no_idle = 1'b0;
   logic hold_rsp;
   logic [7:0] frame_q[$];
   deframe_checker sb;

   clfp_req_if req_ch();
   clfp_rsp_if rsp_ch();
   clfp_csr_if csr_ch();

   content_length_frame_parser_core i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_idle();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_body_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 16);
      if (r < 95) return $urandom_range(17, 64);
      return $urandom_range(65, 300);
   endfunction

   function automatic void put_byte(logic [7:0] b);
      frame_q = {frame_q, b};
   endfunction

   function automatic void put_text(string s);
      int k;
      for (k = 0; k < s.len(); k++) put_byte(s[k]);
   endfunction

   function automatic void put_eol(bit with_cr);
      if (with_cr) put_byte(CHAR_CR);
      put_byte(CHAR_LF);
   endfunction

   function automatic void put_blanks(int unsigned most);
      repeat ($urandom_range(0, most)) put_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   function automatic void put_length_line(int unsigned n);
      string      nm;
      logic [7:0] c;
      int         k;
      nm = "content-length";
      for (k = 0; k < nm.len(); k++) begin
         c = nm[k];
         if (c >= "a" && c <= "z" && $urandom_range(0, 3) == 0) c = c - 8'h20;
         put_byte(c);
      end
      put_byte(CHAR_COLON);
      put_blanks(2);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_byte("0");
      put_text($sformatf("%0d", n));
      put_blanks(2);
      put_eol(1'($urandom_range(0, 1)));
   endfunction

   // the name never starts with c, so the line is never taken for a length
   function automatic void put_other_header();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CHAR_COLON || c == CHAR_LF || c == "c" || c == "C");
      put_byte(c);
      repeat ($urandom_range(0, 6)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_COLON || c == CHAR_LF);
         put_byte(c);
      end
      put_byte(CHAR_COLON);
      repeat ($urandom_range(0, 10)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_LF);
         put_byte(c);
      end
      put_eol(1'($urandom_range(0, 1)));
   endfunction

   // queue one well-formed frame; return its header size
   function automatic int unsigned build_frame(int unsigned n);
      int unsigned others;
      int unsigned at;
      int unsigned k;
      int unsigned hsz;
      others = $urandom_range(0, 3);
      at     = $urandom_range(0, others);
      for (k = 0; k <= others; k++) begin
         if (k == at) put_length_line(n);
         else put_other_header();
      end
      put_eol(1'($urandom_range(0, 1)));
      hsz = frame_q.size();
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      return hsz;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eoi);
      int unsigned gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.track_input(b, eoi);
      items_sent++;
   endtask

   task automatic send_frame();
      int k;
      for (k = 0; k < frame_q.size(); k++) send_byte(frame_q[k], 1'b0);
      frame_q.delete();
   endtask

   // hold the stream until all results are out and the pipeline has drained
   task automatic await_idle();
      req_ch.valid <= 1'b0;
      while (sb.due_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      sb.write_reg(idx, value);
   endtask

   task automatic apply_limits(input logic [HDR_LIMIT_W-1:0] hl, input logic [LEN_W-1:0] bl);
      await_idle();
      write_csr(CSR_HEADER_LIMIT, LEN_W'(hl));
      // unused indexes must leave both limits alone
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                   LEN_W'($urandom_range(0, 33554431)));
      write_csr(CSR_BODY_LIMIT, bl);
      csr_ch.valid <= 1'b0;
   endtask

   // receiving side: check each accepted result, then decide ready for the next edge
   initial begin
      parse_result_type got;
      int unsigned      stall;
      bit               hold_taken;
      stall      = 0;
      hold_taken = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.kind        = rsp_ch.kind;
            got.body_byte   = rsp_ch.body_byte;
            got.last_body   = rsp_ch.last_body;
            got.fault_code  = rsp_ch.fault_code;
            got.body_length = rsp_ch.body_length;
            sb.match_output(got);
         end
         if (hold_rsp === 1'b1 && !hold_taken) begin
            stall      = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_idle();
         end
      end
   end

   initial begin
      int unsigned n;
      int unsigned hsz;
      int unsigned goal;
      int unsigned phase;
      int unsigned w;
      logic [3:0]  ending;
      bit          pressed;
      bit          paused;
      sb = new();
      pressed = 1'b0;
      paused  = 1'b0;
      reset               <= 1'b1;
      hold_rsp            <= 1'b0;
      req_ch.valid        <= 1'b0;
      req_ch.data_byte    <= '0;
      req_ch.end_of_input <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_HEADER_LIMIT;
      csr_ch.data         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset limits: CR inside a line, upper-case name, padded value, body byte extremes
      put_text("X-Note: a");
      put_byte(CHAR_CR);
      put_eol(1'b1);
      put_text("CONTENT-LENGTH:");
      put_byte(CHAR_TAB);
      put_text("007 ");
      put_byte(CHAR_TAB);
      put_eol(1'b1);
      put_eol(1'b1);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(CHAR_LF);
      put_byte(CHAR_CR);
      put_byte(CHAR_COLON);
      put_byte(8'h80);
      put_byte(8'h7F);
      send_frame();

      // both limits met exactly
      n   = $urandom_range(1, 30);
      hsz = build_frame(n);
      apply_limits(HDR_LIMIT_W'(hsz), LEN_W'(n));
      send_frame();

      // smallest frame under the smallest body limit
      put_text("content-length:1");
      put_eol(1'b0);
      put_eol(1'b0);
      put_byte(8'($urandom_range(0, 255)));
      apply_limits(HDR_LIMIT_W'(frame_q.size() - 1), LEN_W'(1));
      send_frame();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       apply_limits(16'hFFFF, HARD_BODY_MAX);
            1:       apply_limits(HDR_LIMIT_W'($urandom_range(300, 65535)), ACC_SAT);
            default: apply_limits(HDR_LIMIT_W'($urandom_range(300, 65535)),
                                  LEN_W'($urandom_range(300, HARD_BODY_MAX)));
         endcase
         no_idle = (phase == 2);
         goal    = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            n = pick_body_len();
            // stall the receiver while a long body keeps coming
            if (phase == 3 && !pressed) begin
               hold_rsp <= 1'b1;
               n        = PRESSURE_LEN;
               pressed  = 1'b1;
            end
            void'(build_frame(n));
            send_frame();
            if (phase == 4 && !paused) begin
               await_idle();
               paused = 1'b1;
            end
         end
      end
      no_idle = 1'b0;

      // the parser halts for good on its first error or clean end, so each run closes
      // the stream on one randomly chosen ending
      ending = 4'($urandom_range(0, END_CLEAN));
      case (ending)
         ERR_INCOMPLETE_HEADERS: begin
            put_text("content-le");
            send_frame();
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         ERR_HEADER_LIMIT: begin
            apply_limits(HDR_LIMIT_W'(1), HARD_BODY_MAX);
            put_text("ab");
            send_frame();
         end
         ERR_MALFORMED_LINE: begin
            if ($urandom_range(0, 1)) put_text("abc");
            else put_text(":x");
            put_eol(1'($urandom_range(0, 1)));
            send_frame();
         end
         ERR_DUPLICATE_LENGTH: begin
            put_length_line(5);
            put_length_line(9);
            send_frame();
         end
         ERR_EMPTY_LENGTH: begin
            put_text("Content-Length:");
            put_blanks(3);
            put_eol(1'($urandom_range(0, 1)));
            send_frame();
         end
         ERR_INVALID_LENGTH: begin
            put_text("content-length: ");
            case ($urandom_range(0, 3))
               0:       put_text("1x");
               1:       put_text("+4");
               2:       put_text("1 2");
               default: put_text("-1");
            endcase
            put_eol(1'($urandom_range(0, 1)));
            send_frame();
         end
         ERR_LENGTH_RANGE: begin
            case ($urandom_range(0, 3))
               0: put_text("content-length: 0");
               1: put_text("content-length: 000099999999999");
               2: begin
                  apply_limits(16'hFFFF, ACC_SAT);
                  put_text("content-length: 16777217");
               end
               default: begin
                  apply_limits(16'hFFFF, LEN_W'(1));
                  put_text("content-length: 2");
               end
            endcase
            put_eol(1'($urandom_range(0, 1)));
            send_frame();
         end
         ERR_MISSING_LENGTH: begin
            if ($urandom_range(0, 1)) put_other_header();
            put_eol(1'($urandom_range(0, 1)));
            send_frame();
         end
         ERR_TRUNCATED_BODY: begin
            n = $urandom_range(2, 30);
            void'(build_frame(n));
            repeat ($urandom_range(1, n - 1)) frame_q.delete(frame_q.size() - 1);
            send_frame();
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase

      // halted: these must draw no result
      repeat (24) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_ch.valid <= 1'b0;

      for (w = 0; w < DRAIN_CYCLES && sb.due_outputs.size() != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (sb.due_outputs.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.due_outputs.size()));

      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
